@@ hdl/sbss_pkg.sv @@
// ----------------------------------------------------------------------------
// sbss_pkg
// Shared constants and types for the binned SAH split selector.
// ----------------------------------------------------------------------------
package sbss_pkg;

  localparam int BINS_DEF       = 16;
  localparam int COORD_BITS_DEF = 32;

  // cost pipeline depth in cycles (extents/products, area, partial products)
  localparam int COST_LAT = 3;

  typedef enum logic [2:0] {
    CFG_AXIS_ORIGIN   = 3'd0,
    CFG_AXIS_SCALE    = 3'd1,
    CFG_NODE_INV_AREA = 3'd2,
    CFG_TRAV_COST     = 3'd3,
    CFG_ISECT_COST    = 3'd4,
    CFG_MAX_SHAPES    = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] COST_TRAV_RST  = 32'h0001_0000;
  localparam logic [31:0] COST_ISECT_RST = 32'h0001_0000;
  localparam logic [15:0] MAX_SHAPES_RST = 16'd255;

  localparam logic [15:0] CNT_SAT = 16'hFFFF;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL  = 10'b00_0000_0010,
    S_RD   = 10'b00_0000_0100,
    S_MRG  = 10'b00_0000_1000,
    S_SRD  = 10'b00_0001_0000,
    S_SACC = 10'b00_0010_0000,
    S_COST = 10'b00_0100_0000,
    S_SWR  = 10'b00_1000_0000,
    S_FIN1 = 10'b01_0000_0000,
    S_FIN2 = 10'b10_0000_0000
  } state_t;

endpackage

@@ hdl/sbss_ram.sv @@
// ----------------------------------------------------------------------------
// sbss_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sbss_cost.sv @@
// ----------------------------------------------------------------------------
// sbss_cost
// Pipelined box surface area times shape count, saturated to 64 bits.
// ----------------------------------------------------------------------------
module sbss_cost
  import sbss_pkg::*;
#(
  parameter int CB    = COORD_BITS_DEF,
  parameter int CNT_W = 20
) (
  input  logic                 clk,
  input  logic [2:0][CB-1:0]   lo,
  input  logic [2:0][CB-1:0]   hi,
  input  logic [CNT_W-1:0]     cnt,
  output logic [63:0]          cost
);

  localparam int P_W    = 2 * CB;
  localparam int S_W    = 2 * CB - 14;
  localparam int AREA_W = 2 * CB - 13;
  localparam int PP_W   = 32 + CNT_W;

  logic [2:0][CB-1:0] ext;

  for (genvar k = 0; k < 3; k++) begin : g_ext
    logic signed [CB:0] d;
    assign d      = $signed({hi[k][CB-1], hi[k]}) - $signed({lo[k][CB-1], lo[k]});
    assign ext[k] = (d > 0) ? d[CB-1:0] : '0;
  end

  logic [P_W-1:0]    p0, p1, p2;
  logic [CNT_W-1:0]  cnt1, cnt2;
  logic [AREA_W-1:0] area;
  logic [S_W-1:0]    s;
  logic [63:0]       a64;
  logic [PP_W-1:0]   plo, phi;
  logic [64:0]       sum;

  assign s   = S_W'(p0[P_W-1:16]) + S_W'(p1[P_W-1:16]) + S_W'(p2[P_W-1:16]);
  assign a64 = 64'(area);

  always_ff @(posedge clk) begin
    p0   <= P_W'(ext[0]) * P_W'(ext[1]);
    p1   <= P_W'(ext[1]) * P_W'(ext[2]);
    p2   <= P_W'(ext[2]) * P_W'(ext[0]);
    cnt1 <= cnt;
    area <= {s, 1'b0};
    cnt2 <= cnt1;
    plo  <= PP_W'(a64[31:0]) * PP_W'(cnt2);
    phi  <= PP_W'(a64[63:32]) * PP_W'(cnt2);
  end

  assign sum  = {1'b0, phi[31:0], 32'b0} + 65'(plo);
  assign cost = ((phi[PP_W-1:32] != '0) || sum[64]) ? '1 : sum[63:0];

endmodule

@@ hdl/sah_binned_split_select_unit.sv @@
// ----------------------------------------------------------------------------
// sah_binned_split_select_unit
// Binned SAH split selection for one hierarchy node, bins held in RAM.
// ----------------------------------------------------------------------------
// Binning: accept, scale multiply, bin RAM read, merge/write, one shape at a time.
// Last shape: adds a sweep of 2*(BINS-1) cuts, each bound by the bin RAM read and
//   the 3-stage area/cost pipeline, then a multiply state and an output state to decide.
// Result sits in an output register; the next node's shapes are taken meanwhile.
// Reset (rst, synchronous) clears bin valid bits and shape count at once,
//   loads register defaults; no clearing pass.
module sah_binned_split_select_unit
  import sbss_pkg::*;
#(
  parameter int BINS       = BINS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // center_axis, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (32 bits each)
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,
  input  logic         s_tlast,
  // split_go, cut_index[6], left_count[16], right_count[16], best_cost[64], pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CB      = COORD_BITS;
  localparam int IDX_W   = $clog2(BINS);
  localparam int CADDR_W = (BINS > 2) ? $clog2(BINS - 1) : 1;
  localparam int CNT_W   = 16 + IDX_W;
  localparam int WORD_W  = 16 + 6 * CB;
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS - 1);
  localparam logic [IDX_W-1:0] LAST_CUT = IDX_W'(BINS - 2);

  // configuration
  logic [31:0] axis_origin, axis_scale, node_inv_area;
  logic [31:0] trav_cost, isect_cost;
  logic [15:0] max_shapes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_origin   <= '0;
      axis_scale    <= '0;
      node_inv_area <= '0;
      trav_cost     <= COST_TRAV_RST;
      isect_cost    <= COST_ISECT_RST;
      max_shapes    <= MAX_SHAPES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AXIS_ORIGIN:   axis_origin   <= cfg_data;
        CFG_AXIS_SCALE:    axis_scale    <= cfg_data;
        CFG_NODE_INV_AREA: node_inv_area <= cfg_data;
        CFG_TRAV_COST:     trav_cost     <= cfg_data;
        CFG_ISECT_COST:    isect_cost    <= cfg_data;
        CFG_MAX_SHAPES:    max_shapes    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state;
  logic [1:0] wait_cnt;

  // shape being binned
  logic [2:0][CB-1:0] in_lo, in_hi;
  logic               in_last;
  logic [CB-1:0]      diff_mag;
  logic               diff_pos;
  logic [63:0]        mprod;
  logic [IDX_W-1:0]   bidx;
  logic signed [CB:0] diff;

  assign diff = $signed({s_tdata[CB-1], s_tdata[CB-1:0]})
              - $signed({axis_origin[CB-1], axis_origin[CB-1:0]});

  // bin RAM
  logic [BINS-1:0]   bin_valid;
  logic              vld_q;
  logic              bram_we;
  logic [IDX_W-1:0]  bram_raddr;
  logic [WORD_W-1:0] bram_rdata, bram_wdata;
  logic [15:0]       rd_cnt;
  logic [2:0][CB-1:0] rd_lo, rd_hi, mrg_lo, mrg_hi;
  logic              first;
  logic [IDX_W-1:0]  sidx;

  assign rd_cnt = vld_q ? bram_rdata[15:0] : '0;
  assign first  = (rd_cnt == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_lo[k]  = bram_rdata[16 + k * CB +: CB];
      rd_hi[k]  = bram_rdata[16 + (3 + k) * CB +: CB];
      mrg_lo[k] = (first || $signed(in_lo[k]) < $signed(rd_lo[k])) ? in_lo[k] : rd_lo[k];
      mrg_hi[k] = (first || $signed(in_hi[k]) > $signed(rd_hi[k])) ? in_hi[k] : rd_hi[k];
    end
    bram_wdata = {mrg_hi, mrg_lo, (rd_cnt == CNT_SAT) ? rd_cnt : rd_cnt + 16'd1};
  end

  assign bram_we    = (state == S_MRG);
  assign bram_raddr = (state == S_RD) ?
                      (!diff_pos ? '0 :
                       (mprod[63:32] > 32'(BINS - 1)) ? LAST_BIN : mprod[32 +: IDX_W]) :
                      sidx;

  sbss_ram #(.WIDTH(WORD_W), .DEPTH(BINS)) u_bins (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bidx),
    .wdata (bram_wdata),
    .raddr (bram_raddr),
    .rdata (bram_rdata)
  );

  // sweep state
  logic               bwd;
  logic [CNT_W-1:0]   acc_cnt, full_cnt;
  logic               acc_valid;
  logic [2:0][CB-1:0] acc_lo, acc_hi;
  logic [63:0]        cost;
  logic [15:0]        shape_total;

  sbss_cost #(.CB(CB), .CNT_W(CNT_W)) u_cost (
    .clk  (clk),
    .lo   (acc_lo),
    .hi   (acc_hi),
    .cnt  (acc_cnt),
    .cost (cost)
  );

  // cut cost RAM
  logic [CADDR_W-1:0] caddr;
  logic [63:0]        crdata, cwdata, fwd_c, bwd_sum;
  logic [64:0]        csum;
  logic               cram_we;

  assign caddr   = bwd ? CADDR_W'(sidx - IDX_W'(1)) : CADDR_W'(sidx);
  assign fwd_c   = (acc_cnt == '0) ? 64'd0 : cost;
  assign csum    = {1'b0, crdata} + {1'b0, cost};
  assign bwd_sum = (acc_cnt == '0) ? crdata : (csum[64] ? '1 : csum[63:0]);
  assign cwdata  = bwd ? bwd_sum : fwd_c;
  assign cram_we = (state == S_SWR);

  sbss_ram #(.WIDTH(64), .DEPTH(BINS - 1), .AW(CADDR_W)) u_cuts (
    .clk   (clk),
    .we    (cram_we),
    .waddr (caddr),
    .wdata (cwdata),
    .raddr (caddr),
    .rdata (crdata)
  );

  // best cut
  logic [63:0]      best;
  logic [IDX_W-1:0] best_i;
  logic [CNT_W-1:0] best_right;

  // decision
  logic [63:0]  m_hi, m_lo;
  logic [47:0]  limit;
  logic [CNT_W-1:0] left_u;
  logic [63:0]  norm, total;
  logic [64:0]  tot65;
  logic         go, out_free;
  logic [15:0]  left_s, right_s;
  logic [103:0] out_data;

  assign norm     = m_hi + {32'b0, m_lo[63:32]};
  assign tot65    = {33'b0, trav_cost} + {1'b0, norm};
  assign total    = tot65[64] ? '1 : tot65[63:0];
  assign go       = (shape_total > 16'd2) &&
                    ((shape_total > max_shapes) || (total < 64'(limit))) &&
                    (left_u != '0) && (best_right != '0);
  assign left_s   = (left_u > CNT_W'(CNT_SAT)) ? CNT_SAT : left_u[15:0];
  assign right_s  = (best_right > CNT_W'(CNT_SAT)) ? CNT_SAT : best_right[15:0];
  assign out_free = !m_tvalid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bin_valid   <= '0;
      shape_total <= '0;
      m_tvalid    <= 1'b0;
      wait_cnt    <= '0;
      sidx        <= '0;
      bwd         <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN2) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int k = 0; k < 3; k++) begin
              in_lo[k] <= s_tdata[32 * (1 + k) +: CB];
              in_hi[k] <= s_tdata[32 * (4 + k) +: CB];
            end
            in_last  <= s_tlast;
            diff_pos <= (diff > 0);
            diff_mag <= diff[CB-1:0];
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          mprod <= 64'(diff_mag) * 64'(axis_scale);
          state <= S_RD;
        end
        S_RD: begin
          bidx  <= bram_raddr;
          vld_q <= bin_valid[bram_raddr];
          state <= S_MRG;
        end
        S_MRG: begin
          bin_valid[bidx] <= 1'b1;
          if (shape_total != CNT_SAT) begin
            shape_total <= shape_total + 16'd1;
          end
          if (in_last) begin
            sidx      <= '0;
            bwd       <= 1'b0;
            acc_cnt   <= '0;
            acc_valid <= 1'b0;
            state     <= S_SRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SRD: begin
          // bin_valid for the merged bin was set in S_MRG, before the first S_SRD, so it is current
          vld_q <= bin_valid[sidx];
          state <= S_SACC;
        end
        S_SACC: begin
          acc_cnt <= acc_cnt + CNT_W'(rd_cnt);
          if (rd_cnt != '0) begin
            for (int k = 0; k < 3; k++) begin
              if (!acc_valid || $signed(rd_lo[k]) < $signed(acc_lo[k])) acc_lo[k] <= rd_lo[k];
              if (!acc_valid || $signed(rd_hi[k]) > $signed(acc_hi[k])) acc_hi[k] <= rd_hi[k];
            end
            acc_valid <= 1'b1;
          end
          if (bwd && sidx == LAST_BIN) begin
            full_cnt <= full_cnt + CNT_W'(rd_cnt);
          end
          wait_cnt <= '0;
          state    <= S_COST;
        end
        S_COST: begin
          wait_cnt <= wait_cnt + 2'd1;
          if (wait_cnt == 2'(COST_LAT - 1)) begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          if (!bwd) begin
            if (sidx == LAST_CUT) begin
              full_cnt  <= acc_cnt;
              bwd       <= 1'b1;
              sidx      <= LAST_BIN;
              acc_cnt   <= '0;
              acc_valid <= 1'b0;
            end else begin
              sidx <= sidx + IDX_W'(1);
            end
            state <= S_SRD;
          end else begin
            // descending scan: ties move to the lower cut
            if (sidx == LAST_BIN || bwd_sum <= best) begin
              best       <= bwd_sum;
              best_i     <= sidx - IDX_W'(1);
              best_right <= acc_cnt;
            end
            if (sidx == IDX_W'(1)) begin
              state <= S_FIN1;
            end else begin
              sidx  <= sidx - IDX_W'(1);
              state <= S_SRD;
            end
          end
        end
        S_FIN1: begin
          m_hi   <= 64'(best[63:32]) * 64'(node_inv_area);
          m_lo   <= 64'(best[31:0]) * 64'(node_inv_area);
          limit  <= 48'(shape_total) * 48'(isect_cost);
          left_u <= full_cnt - best_right;
          state  <= S_FIN2;
        end
        S_FIN2: begin
          if (out_free) begin
            out_data    <= {1'b0, best, right_s, left_s, 6'(best_i), go};
            m_tvalid    <= 1'b1;
            bin_valid   <= '0;
            shape_total <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/sbss_checker.sv @@
// ----------------------------------------------------------------------------
// sbss_checker
// Port-level checks on the split selector, bound to the top level.
// ----------------------------------------------------------------------------
module sbss_checker #(
  parameter int BINS = 16
) (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a split needs both sides populated
  a_sides: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[22:7] != 16'd0) && (m_tdata[38:23] != 16'd0))
    else $error("split with an empty side");

  // cut index stays within the cut range
  a_cut: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:1] <= 6'(BINS - 2))
    else $error("cut index out of range");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sah_binned_split_select_unit sbss_checker #(.BINS(BINS)) u_sbss_checker (.*);
